// ----- sv/psnr_pkg.sv -----
// shared constants, codes and command/status types for the psnr metric core
// no dependencies
package psnr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_SAMPLES = 16384;
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = 64;
  localparam int LOG_W = 22;                 // q6.16 logarithm
  localparam int DIV_W = SAMPLE_BITS + 12;   // dividend bits of the ratio
  localparam int PROD_W = LOG_W + 18;
  localparam logic [17:0] TEN_LOG10_2_Q16 = 18'd197283;
  localparam int FRAC_STEPS = 16;
  localparam int NORM_STEPS = 6;

  localparam logic [4:0] OP_NOP      = 5'd0;
  localparam logic [4:0] OP_CAPTURE  = 5'd1;
  localparam logic [4:0] OP_DIFF     = 5'd2;
  localparam logic [4:0] OP_SQUARE   = 5'd3;
  localparam logic [4:0] OP_ACCUM    = 5'd4;
  localparam logic [4:0] OP_RANGE    = 5'd5;
  localparam logic [4:0] OP_RSQ      = 5'd6;
  localparam logic [4:0] OP_NUM_LO   = 5'd7;
  localparam logic [4:0] OP_NUM_HI   = 5'd8;
  localparam logic [4:0] OP_LOG_LOAD = 5'd9;
  localparam logic [4:0] OP_LOG_NORM = 5'd10;
  localparam logic [4:0] OP_LOG_MANT = 5'd11;
  localparam logic [4:0] OP_LOG_FRAC = 5'd12;
  localparam logic [4:0] OP_LOG_SAVE = 5'd13;
  localparam logic [4:0] OP_PSNR_MUL = 5'd14;
  localparam logic [4:0] OP_DIV_INIT = 5'd15;
  localparam logic [4:0] OP_DIV_STEP = 5'd16;
  localparam logic [4:0] OP_OUTPUT   = 5'd17;

  typedef struct packed {
    logic [4:0] op;
    logic [5:0] step;
    logic       second;   // log of the error sum rather than the numerator
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

// ----- sv/psnr_ctrl.sv -----
// sequencer for the psnr metric core: per-item accumulation and the final math
// depends on psnr_pkg
module psnr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  psnr_pkg::status_t sts,
  output psnr_pkg::cmd_t    cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DIFF  = 5'd1;
  localparam logic [4:0] S_SQ    = 5'd2;
  localparam logic [4:0] S_ACC   = 5'd3;
  localparam logic [4:0] S_RANGE = 5'd4;
  localparam logic [4:0] S_RSQ   = 5'd5;
  localparam logic [4:0] S_NLO   = 5'd6;
  localparam logic [4:0] S_NHI   = 5'd7;
  localparam logic [4:0] S_LLOAD = 5'd8;
  localparam logic [4:0] S_LNORM = 5'd9;
  localparam logic [4:0] S_LMANT = 5'd10;
  localparam logic [4:0] S_LFRAC = 5'd11;
  localparam logic [4:0] S_LSAVE = 5'd12;
  localparam logic [4:0] S_PMUL  = 5'd13;
  localparam logic [4:0] S_DINIT = 5'd14;
  localparam logic [4:0] S_DSTEP = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;

  logic [4:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       second_r, second_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    second_nxt    = second_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd.op        = psnr_pkg::OP_NOP;
    cmd.step      = cnt_r;
    cmd.second    = second_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = psnr_pkg::OP_CAPTURE;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.op    = psnr_pkg::OP_DIFF;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op    = psnr_pkg::OP_SQUARE;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = psnr_pkg::OP_ACCUM;
        state_nxt = sts.last ? S_RANGE : S_IDLE;
      end
      S_RANGE: begin
        cmd.op    = psnr_pkg::OP_RANGE;
        state_nxt = S_RSQ;
      end
      S_RSQ: begin
        cmd.op    = psnr_pkg::OP_RSQ;
        state_nxt = S_NLO;
      end
      S_NLO: begin
        cmd.op    = psnr_pkg::OP_NUM_LO;
        state_nxt = S_NHI;
      end
      S_NHI: begin
        cmd.op     = psnr_pkg::OP_NUM_HI;
        second_nxt = 1'b0;
        state_nxt  = S_LLOAD;
      end
      S_LLOAD: begin
        cmd.op    = psnr_pkg::OP_LOG_LOAD;
        cnt_nxt   = '0;
        state_nxt = S_LNORM;
      end
      S_LNORM: begin
        cmd.op = psnr_pkg::OP_LOG_NORM;
        if (cnt_r == 6'(psnr_pkg::NORM_STEPS - 1)) begin
          state_nxt = S_LMANT;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_LMANT: begin
        cmd.op    = psnr_pkg::OP_LOG_MANT;
        cnt_nxt   = '0;
        state_nxt = S_LFRAC;
      end
      S_LFRAC: begin
        cmd.op = psnr_pkg::OP_LOG_FRAC;
        if (cnt_r == 6'(psnr_pkg::FRAC_STEPS - 1)) begin
          state_nxt = S_LSAVE;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_LSAVE: begin
        cmd.op = psnr_pkg::OP_LOG_SAVE;
        if (second_r) begin
          state_nxt = S_PMUL;
        end else begin
          second_nxt = 1'b1;
          state_nxt  = S_LLOAD;
        end
      end
      S_PMUL: begin
        cmd.op    = psnr_pkg::OP_PSNR_MUL;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.op    = psnr_pkg::OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = psnr_pkg::OP_DIV_STEP;
        if (cnt_r == 6'(psnr_pkg::DIV_W - 1)) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_OUT: begin
        // wait until the output register is free
        if (!(out_valid_r && out_stall)) begin
          cmd.op        = psnr_pkg::OP_OUTPUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result appeared outside the output step");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == psnr_pkg::OP_OUTPUT) |-> !(out_valid_r && out_stall))
    else $error("waiting result overwritten");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_DIFF)
    else $error("accepted item not processed");
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DSTEP && cnt_r == 6'(psnr_pkg::DIV_W - 1)) |=> state_r == S_OUT)
    else $error("divider did not finish");
`endif

endmodule

// ----- sv/psnr_dp.sv -----
// datapath of the psnr metric core: accumulators, log2 unit, divider, result register
// depends on psnr_pkg
module psnr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [23:0]                  in_orig_sample,
  input  logic signed [23:0]                  in_recon_sample,
  input  logic                                in_last_sample,
  input  psnr_pkg::cmd_t                      cmd,
  output psnr_pkg::status_t                   sts,
  output logic signed [15:0]                  out_psnr_db_q8,
  output logic [15:0]                         out_max_rel_error_q12,
  output logic                                out_zero_error,
  output logic                                out_flat_range,
  output logic                                out_count_overflow
);

  localparam int SB = psnr_pkg::SAMPLE_BITS;
  localparam int CW = psnr_pkg::CNT_W;
  localparam int LW = psnr_pkg::LOG_W;
  localparam int DW = psnr_pkg::DIV_W;
  localparam int PW = psnr_pkg::PROD_W;

  // captured item
  logic signed [SB-1:0] orig_r, recon_r;
  logic                 last_r;
  // accumulators
  logic signed [SB-1:0] lo_r, hi_r;
  logic [SB-1:0]        lae_r;
  logic [63:0]          sum_r;
  logic [CW-1:0]        count_r;
  logic                 ovf_r;
  logic [SB-1:0]        ae_r;
  logic                 acc_en_r;
  logic [2*SB-1:0]      sq_r;
  // final math
  logic [SB-1:0]        range_r;
  logic [2*SB-1:0]      rr_r;
  logic [SB+CW-1:0]     nlo_r;
  logic [63:0]          num_r;
  logic [63:0]          lx_r;
  logic [5:0]           le_r;
  logic [31:0]          lm_r;
  logic [15:0]          lf_r;
  logic [LW-1:0]        log_a_r;
  logic [LW-1:0]        log_b_r;
  logic [PW-1:0]        prod_r;
  logic                 dneg_r;
  logic [SB-1:0]        rem_r;
  logic [DW-1:0]        dq_r;

  logic signed [SB:0]   err;
  logic [SB-1:0]        ae;
  logic [SB+CW-1:0]     nhi;
  logic [63:0]          msq;
  logic [32:0]          mt;
  logic signed [LW:0]   dlog;
  logic [LW-1:0]        dabs;
  logic [SB:0]          trial;
  logic [PW:0]          rnd;
  logic [16:0]          mag;
  logic [15:0]          psnr;
  logic [15:0]          rel;
  logic                 zero_err, flat;

  assign sts.last = last_r;

  assign err   = {orig_r[SB-1], orig_r} - {recon_r[SB-1], recon_r};
  assign ae    = err[SB] ? SB'(-err) : err[SB-1:0];
  assign nhi   = rr_r[2*SB-1:SB] * count_r;
  assign msq   = lm_r * lm_r;
  assign mt    = msq[63:31];
  assign dlog  = {1'b0, log_a_r} - {1'b0, log_b_r};
  assign dabs  = dlog[LW] ? LW'(-dlog) : dlog[LW-1:0];
  assign trial = {rem_r, dq_r[DW-1]};

  // psnr rounding half away from zero, then saturation
  assign rnd = {1'b0, prod_r} + ((PW + 1)'(1) << 23);
  assign mag = rnd[PW:24];
  assign zero_err = (sum_r == '0);
  assign flat     = (range_r == '0);

  always_comb begin
    if (zero_err) begin
      psnr = 16'h7FFF;
    end else if (flat) begin
      psnr = 16'h8000;
    end else if (!dneg_r) begin
      psnr = (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
    end else begin
      psnr = (mag > 17'd32768) ? 16'h8000 : 16'(17'h10000 - mag);
    end
    if (flat || dq_r[DW-1:16] != '0) begin
      rel = 16'hFFFF;
    end else begin
      rel = dq_r[15:0];
    end
  end

  // accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lae_r   <= '0;
      sum_r   <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      lo_r    <= '0;
      hi_r    <= '0;
    end else begin
      case (cmd.op)
        psnr_pkg::OP_DIFF: begin
          if (count_r >= CW'(psnr_pkg::MAX_SAMPLES)) begin
            ovf_r <= 1'b1;
          end else begin
            if (count_r == '0) begin
              lo_r <= orig_r;
              hi_r <= orig_r;
            end else begin
              if (orig_r > hi_r) hi_r <= orig_r;
              if (orig_r < lo_r) lo_r <= orig_r;
            end
            if (ae > lae_r) lae_r <= ae;
          end
        end
        psnr_pkg::OP_ACCUM: begin
          if (acc_en_r) begin
            sum_r   <= sum_r + 64'(sq_r);
            count_r <= count_r + CW'(1);
          end
        end
        psnr_pkg::OP_OUTPUT: begin
          lae_r   <= '0;
          sum_r   <= '0;
          count_r <= '0;
          ovf_r   <= 1'b0;
          lo_r    <= '0;
          hi_r    <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      psnr_pkg::OP_CAPTURE: begin
        orig_r  <= in_orig_sample[SB-1:0];
        recon_r <= in_recon_sample[SB-1:0];
        last_r  <= in_last_sample;
      end
      psnr_pkg::OP_DIFF: begin
        ae_r     <= ae;
        acc_en_r <= (count_r < CW'(psnr_pkg::MAX_SAMPLES));
      end
      psnr_pkg::OP_SQUARE: begin
        sq_r <= ae_r * ae_r;
      end
      psnr_pkg::OP_RANGE: begin
        range_r <= SB'({hi_r[SB-1], hi_r} - {lo_r[SB-1], lo_r});
      end
      psnr_pkg::OP_RSQ: begin
        rr_r <= range_r * range_r;
      end
      psnr_pkg::OP_NUM_LO: begin
        nlo_r <= rr_r[SB-1:0] * count_r;
      end
      psnr_pkg::OP_NUM_HI: begin
        num_r <= 64'(nlo_r) + (64'(nhi) << SB);
      end
      psnr_pkg::OP_LOG_LOAD: begin
        lx_r <= cmd.second ? sum_r : num_r;
        le_r <= 6'd63;
      end
      psnr_pkg::OP_LOG_NORM: begin
        // binary search for the leading one, widest chunk first
        case (cmd.step[2:0])
          3'd0: if (lx_r[63:32] == '0) begin lx_r <= lx_r << 32; le_r <= le_r - 6'd32; end
          3'd1: if (lx_r[63:48] == '0) begin lx_r <= lx_r << 16; le_r <= le_r - 6'd16; end
          3'd2: if (lx_r[63:56] == '0) begin lx_r <= lx_r << 8;  le_r <= le_r - 6'd8;  end
          3'd3: if (lx_r[63:60] == '0) begin lx_r <= lx_r << 4;  le_r <= le_r - 6'd4;  end
          3'd4: if (lx_r[63:62] == '0) begin lx_r <= lx_r << 2;  le_r <= le_r - 6'd2;  end
          3'd5: if (lx_r[63] == 1'b0)  begin lx_r <= lx_r << 1;  le_r <= le_r - 6'd1;  end
          default: begin
          end
        endcase
      end
      psnr_pkg::OP_LOG_MANT: begin
        lm_r <= lx_r[63:32];
        lf_r <= '0;
      end
      psnr_pkg::OP_LOG_FRAC: begin
        // square the q1.31 mantissa; a value of two or more yields a one bit
        lm_r <= mt[32] ? mt[32:1] : mt[31:0];
        lf_r <= {lf_r[14:0], mt[32]};
      end
      psnr_pkg::OP_LOG_SAVE: begin
        if (cmd.second) begin
          log_b_r <= {le_r, lf_r};
        end else begin
          log_a_r <= {le_r, lf_r};
        end
      end
      psnr_pkg::OP_PSNR_MUL: begin
        prod_r <= dabs * psnr_pkg::TEN_LOG10_2_Q16;
        dneg_r <= dlog[LW];
      end
      psnr_pkg::OP_DIV_INIT: begin
        rem_r <= '0;
        dq_r  <= {lae_r, 12'd0};
      end
      psnr_pkg::OP_DIV_STEP: begin
        // restoring division, one quotient bit per step
        if (trial >= {1'b0, range_r}) begin
          rem_r <= SB'(trial - {1'b0, range_r});
          dq_r  <= {dq_r[DW-2:0], 1'b1};
        end else begin
          rem_r <= trial[SB-1:0];
          dq_r  <= {dq_r[DW-2:0], 1'b0};
        end
      end
      psnr_pkg::OP_OUTPUT: begin
        out_psnr_db_q8        <= psnr;
        out_max_rel_error_q12 <= rel;
        out_zero_error        <= zero_err;
        out_flat_range        <= flat;
        out_count_overflow    <= ovf_r;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/psnr_and_max_error_metric_core.sv -----
// top level of the psnr and max relative error metric core
// depends on psnr_pkg, psnr_ctrl and psnr_dp
//
// Streams pairs of original and reconstructed signed samples and, on the pair
// marked last, returns one item: psnr in signed q8.8 dB (10*log10 of
// range^2*count/sum of squared errors), largest abs error over range in
// unsigned q4.12, and the zero error, flat range and count overflow flags.
// Items are taken one at a time through a sequencer: a pair that is not last
// takes capture, difference, square and accumulate steps; a last pair adds
// range and numerator products, two log2 passes (a 6-step leading-one search
// and 16 mantissa squarings on one 32x32 multiplier), one scaling multiply and
// a 36-step restoring divider, plus any wait for the output register. The
// result register lets the next data set start while a result is pending.
module psnr_and_max_error_metric_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_orig_sample,
  input  logic signed [23:0] in_recon_sample,
  input  logic               in_last_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_psnr_db_q8,
  output logic [15:0]        out_max_rel_error_q12,
  output logic               out_zero_error,
  output logic               out_flat_range,
  output logic               out_count_overflow
);

  psnr_pkg::cmd_t    cmd;
  psnr_pkg::status_t sts;

  psnr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  psnr_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_orig_sample        (in_orig_sample),
    .in_recon_sample       (in_recon_sample),
    .in_last_sample        (in_last_sample),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_psnr_db_q8        (out_psnr_db_q8),
    .out_max_rel_error_q12 (out_max_rel_error_q12),
    .out_zero_error        (out_zero_error),
    .out_flat_range        (out_flat_range),
    .out_count_overflow    (out_count_overflow)
  );

endmodule
